// File: rtl/interval_schedule_select_core_defines.svh
// Assertion macros used by the core RTL.
`ifndef INTERVAL_SCHEDULE_SELECT_CORE_DEFINES_SVH
`define INTERVAL_SCHEDULE_SELECT_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle check, sampled on the rising clock edge
`define ISS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// cause in this cycle, effect in the next
`define ISS_ASSERT_NEXT(lbl, cause, effect, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
      else $error(msg);
`else
`define ISS_ASSERT(lbl, prop, msg)
`define ISS_ASSERT_NEXT(lbl, cause, effect, msg)
`endif

`endif

// File: rtl/iss_pkg.sv
`timescale 1ns / 1ps

package iss_pkg;

   localparam int ISS_FIELD_W     = 16;
   localparam int ISS_POS_W       = 7;
   localparam int ISS_MAX_DEFAULT = 64;
   localparam int ISS_TIME_DEFAULT = 16;

   typedef struct packed {
      logic [ISS_FIELD_W-1:0] start_time;
      logic [ISS_FIELD_W-1:0] end_time;
      logic                   last_meeting;
   } req_type;

   typedef struct packed {
      logic [ISS_POS_W-1:0] meeting_number;
      logic                 last_of_run;
      logic                 overflowed;
   } rsp_type;

   // chain control, same for every cell
   typedef struct packed {
      logic insert;   // place the new interval, pushing later ends up
      logic shift;    // move every entry one cell toward the head
   } cell_ctl_type;

   // control from the sequencer to the selector
   typedef struct packed {
      logic step;      // judge the head cell this cycle
      logic flush;     // scan done, release the held pick as last
      logic overflow;  // set had dropped meetings
   } scan_ctl_type;

   typedef enum logic {
      ST_LOAD,
      ST_SCAN
   } state_type;

endpackage

// File: rtl/iss_cell.sv
`timescale 1ns / 1ps

module iss_cell import iss_pkg::*; #(
   parameter int TIME_BITS = ISS_TIME_DEFAULT
) (
   input  logic                 clock,
   input  cell_ctl_type         ctl,
   input  logic                 occupied,
   input  logic                 prev_gt,
   input  logic [TIME_BITS-1:0] new_start,
   input  logic [TIME_BITS-1:0] new_finish,
   input  logic [ISS_POS_W-1:0] new_pos,
   input  logic [TIME_BITS-1:0] lower_start,
   input  logic [TIME_BITS-1:0] lower_finish,
   input  logic [ISS_POS_W-1:0] lower_pos,
   input  logic [TIME_BITS-1:0] upper_start,
   input  logic [TIME_BITS-1:0] upper_finish,
   input  logic [ISS_POS_W-1:0] upper_pos,
   output logic [TIME_BITS-1:0] cell_start,
   output logic [TIME_BITS-1:0] cell_finish,
   output logic [ISS_POS_W-1:0] cell_pos,
   output logic                 cell_gt
);

   logic [TIME_BITS-1:0] st_ff, st_in;
   logic [TIME_BITS-1:0] fin_ff, fin_in;
   logic [ISS_POS_W-1:0] pos_ff, pos_in;

   // empty cells count as later-ending; equal ends stay ahead
   assign cell_gt = !occupied || (fin_ff > new_finish);

   always_comb begin
      st_in  = st_ff;
      fin_in = fin_ff;
      pos_in = pos_ff;
      if (ctl.insert && cell_gt) begin
         if (prev_gt) begin
            st_in  = lower_start;
            fin_in = lower_finish;
            pos_in = lower_pos;
         end else begin
            st_in  = new_start;
            fin_in = new_finish;
            pos_in = new_pos;
         end
      end else if (ctl.shift) begin
         st_in  = upper_start;
         fin_in = upper_finish;
         pos_in = upper_pos;
      end
   end

   always_ff @(posedge clock) begin
      st_ff  <= st_in;
      fin_ff <= fin_in;
      pos_ff <= pos_in;
   end

   assign cell_start  = st_ff;
   assign cell_finish = fin_ff;
   assign cell_pos    = pos_ff;

endmodule

// File: rtl/iss_pick.sv
`timescale 1ns / 1ps

module iss_pick import iss_pkg::*; #(
   parameter int TIME_BITS = ISS_TIME_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  scan_ctl_type         ctl,
   input  logic [TIME_BITS-1:0] head_start,
   input  logic [TIME_BITS-1:0] head_finish,
   input  logic [ISS_POS_W-1:0] head_pos,
   output logic                 rsp_valid,
   output rsp_type              rsp
);

   logic [TIME_BITS-1:0] limit_ff, limit_in;
   logic [ISS_POS_W-1:0] pend_pos_ff, pend_pos_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 take;

   // no pick held yet means this is the first interval of the scan
   assign take = ctl.step && (!pend_valid_ff || (head_start > limit_ff));

   always_comb begin
      limit_in      = limit_ff;
      pend_pos_in   = pend_pos_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      if (take) begin
         limit_in      = head_finish;
         pend_pos_in   = head_pos;
         pend_valid_in = 1'b1;
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{pend_pos_ff, 1'b0, ctl.overflow};
         end
      end
      if (ctl.flush) begin
         pend_valid_in = 1'b0;
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{pend_pos_ff, 1'b1, ctl.overflow};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff    <= limit_in;
      pend_pos_ff <= pend_pos_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: rtl/interval_schedule_select_core.sv
`timescale 1ns / 1ps
// channel   | ports                  | beat taken when
// ----------+------------------------+-----------------------------------------
// request   | start, busy, req       | rising edge with start high, busy low
// response  | rsp_valid, rsp         | rising edge ending the rsp_valid cycle
//
// Loading accepts one beat per cycle while busy is low: each interval drops into
// its sorted place in the cell chain in the cycle it is taken. After the beat
// marked last, busy stays high while the chain shifts one held entry a cycle
// past the head-cell selector, and then while the final pick is released.
// Picks leave at most one per cycle, each held back until the next is taken
// or the scan ends; the final pick shows in the cycle after busy drops.
// Reset is synchronous, active high; the interval store has no reset.
// The receiver cannot stall: every response beat is shown for one cycle only.

`include "interval_schedule_select_core_defines.svh"

module interval_schedule_select_core import iss_pkg::*; #(
   parameter int MAX_MEETINGS = ISS_MAX_DEFAULT,
   parameter int TIME_BITS    = ISS_TIME_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req,
   output logic    rsp_valid,
   output rsp_type rsp
);

   localparam int CW = $clog2(MAX_MEETINGS + 1);

   // sequencer state
   state_type    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;    // meetings held in the chain
   logic [CW-1:0] remain_ff, remain_in;  // entries still to pass the head
   logic          ovf_ff, ovf_in;        // a meeting of this set was dropped

   cell_ctl_type  cell_ctl;
   scan_ctl_type  scan_ctl;
   logic          has_room;

   // new interval, times taken modulo 2^TIME_BITS
   logic [TIME_BITS-1:0] new_start, new_finish;
   logic [ISS_POS_W-1:0] new_pos;

   // cell chain wiring
   logic [TIME_BITS-1:0] c_start  [MAX_MEETINGS];
   logic [TIME_BITS-1:0] c_finish [MAX_MEETINGS];
   logic [ISS_POS_W-1:0] c_pos    [MAX_MEETINGS];
   logic [TIME_BITS-1:0] lo_start  [MAX_MEETINGS];
   logic [TIME_BITS-1:0] lo_finish [MAX_MEETINGS];
   logic [ISS_POS_W-1:0] lo_pos    [MAX_MEETINGS];
   logic [TIME_BITS-1:0] up_start  [MAX_MEETINGS];
   logic [TIME_BITS-1:0] up_finish [MAX_MEETINGS];
   logic [ISS_POS_W-1:0] up_pos    [MAX_MEETINGS];
   logic [MAX_MEETINGS-1:0] c_gt;
   logic [MAX_MEETINGS-1:0] c_prev_gt;
   logic [MAX_MEETINGS-1:0] c_occ;

   assign new_start  = TIME_BITS'(req.start_time);
   assign new_finish = TIME_BITS'(req.end_time);
   // arrival number is the count held plus one, since drops only happen when full
   assign new_pos    = ISS_POS_W'(count_ff) + ISS_POS_W'(1);

   assign busy     = (state_ff == ST_SCAN);
   assign has_room = (count_ff < CW'(MAX_MEETINGS));

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      remain_in = remain_ff;
      ovf_in    = ovf_ff;
      cell_ctl  = '0;
      scan_ctl  = '0;
      scan_ctl.overflow = ovf_ff;
      case (state_ff)
         ST_LOAD: begin
            if (start) begin
               if (has_room) begin
                  cell_ctl.insert = 1'b1;
                  count_in        = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req.last_meeting) begin
                  state_in  = ST_SCAN;
                  remain_in = has_room ? (count_ff + CW'(1)) : count_ff;
               end
            end
         end
         ST_SCAN: begin
            if (remain_ff != '0) begin
               // judge the head entry, then pull the chain down one cell
               scan_ctl.step  = 1'b1;
               cell_ctl.shift = 1'b1;
               remain_in      = remain_ff - CW'(1);
            end else begin
               scan_ctl.flush = 1'b1;
               state_in       = ST_LOAD;
               count_in       = '0;
               ovf_in         = 1'b0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         count_ff  <= '0;
         remain_ff <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         remain_ff <= remain_in;
         ovf_ff    <= ovf_in;
      end
   end

   // the chain: cell 0 holds the earliest end
   for (genvar i = 0; i < MAX_MEETINGS; i++) begin : g_cell
      assign c_occ[i] = (CW'(i) < count_ff);

      if (i == 0) begin : g_head
         // head never takes from below
         assign c_prev_gt[i] = 1'b0;
         assign lo_start[i]  = new_start;
         assign lo_finish[i] = new_finish;
         assign lo_pos[i]    = new_pos;
      end else begin : g_body
         assign c_prev_gt[i] = c_gt[i-1];
         assign lo_start[i]  = c_start[i-1];
         assign lo_finish[i] = c_finish[i-1];
         assign lo_pos[i]    = c_pos[i-1];
      end

      if (i == MAX_MEETINGS - 1) begin : g_tail
         // tail refills with its own stale entry, never read
         assign up_start[i]  = c_start[i];
         assign up_finish[i] = c_finish[i];
         assign up_pos[i]    = c_pos[i];
      end else begin : g_mid
         assign up_start[i]  = c_start[i+1];
         assign up_finish[i] = c_finish[i+1];
         assign up_pos[i]    = c_pos[i+1];
      end

      iss_cell #(
         .TIME_BITS (TIME_BITS)
      ) u_cell (
         .clock        (clock),
         .ctl          (cell_ctl),
         .occupied     (c_occ[i]),
         .prev_gt      (c_prev_gt[i]),
         .new_start    (new_start),
         .new_finish   (new_finish),
         .new_pos      (new_pos),
         .lower_start  (lo_start[i]),
         .lower_finish (lo_finish[i]),
         .lower_pos    (lo_pos[i]),
         .upper_start  (up_start[i]),
         .upper_finish (up_finish[i]),
         .upper_pos    (up_pos[i]),
         .cell_start   (c_start[i]),
         .cell_finish  (c_finish[i]),
         .cell_pos     (c_pos[i]),
         .cell_gt      (c_gt[i])
      );
   end

   // greedy selector on the head cell; holds one pick back to mark the last
   iss_pick #(
      .TIME_BITS (TIME_BITS)
   ) u_pick (
      .clock       (clock),
      .reset       (reset),
      .ctl         (scan_ctl),
      .head_start  (c_start[0]),
      .head_finish (c_finish[0]),
      .head_pos    (c_pos[0]),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp)
   );

   // held count never passes capacity
   `ISS_ASSERT(a_count_bound, count_ff <= CW'(MAX_MEETINGS), "chain count above capacity")
   // a beat refused for room must leave the overflow mark set
   `ISS_ASSERT_NEXT(a_drop_flags, start && !busy && !has_room, ovf_ff, "drop not flagged")
   // inner picks leave during the scan; the final one right after it
   `ISS_ASSERT(a_last_timing, !rsp_valid || (rsp.last_of_run == !busy), "last mark off")

endmodule

// File: bench/interval_schedule_select_core_tb.sv
`timescale 1ns / 1ps

module interval_schedule_select_core_tb;
   import iss_pkg::*;

   localparam int CLOCK_PERIOD  = 8;
   localparam int MEETING_SLOTS = ISS_MAX_DEFAULT;
   localparam int RANDOM_ITEMS  = 220;
   // Slowest legal run is every beat with its longest idle gap and scan;
   // the limit leaves plenty of headroom on top of that.
   localparam int CYCLE_LIMIT   = 400000;
   // Drain covers the longest scan after a closing beat, with up to 64 meetings held.
   localparam int DRAIN_CYCLES  = 2 * MEETING_SLOTS + 16;

   // Running copy of the block: a sorted interval store filled by insertion,
   // and the greedy earliest-finish picks of each closed set, oldest first.
   class schedule_scoreboard;
      logic [ISS_FIELD_W-1:0] held_start [MEETING_SLOTS];
      logic [ISS_FIELD_W-1:0] held_end [MEETING_SLOTS];
      logic [ISS_POS_W-1:0]   held_pos [MEETING_SLOTS];
      int      held_count;
      int      arrivals;
      bit      dropped;
      rsp_type picks_pending[$];
      int      fails;
      int      picks_checked;
      int      sets_closed;
      int      overflow_sets;
      int      meetings_taken;

      function new();
         held_count     = 0;
         arrivals       = 0;
         dropped        = 1'b0;
         fails          = 0;
         picks_checked  = 0;
         sets_closed    = 0;
         overflow_sets  = 0;
         meetings_taken = 0;
      endfunction

      // One accepted request beat: store it in end-time order (ties keep
      // arrival order), and on the closing beat work out the schedule.
      function void note_meeting(req_type item);
         int                     k;
         logic [ISS_FIELD_W-1:0] limit;
         rsp_type                pick;
         rsp_type                run[$];
         meetings_taken++;
         if (held_count < MEETING_SLOTS) begin
            k = held_count;
            while (k > 0 && held_end[k-1] > item.end_time) begin
               held_start[k] = held_start[k-1];
               held_end[k]   = held_end[k-1];
               held_pos[k]   = held_pos[k-1];
               k--;
            end
            held_start[k] = item.start_time;
            held_end[k]   = item.end_time;
            held_pos[k]   = ISS_POS_W'(arrivals + 1);
            held_count++;
            arrivals++;
         end else begin
            dropped = 1'b1;
         end
         if (!item.last_meeting) return;

         sets_closed++;
         if (dropped) overflow_sets++;
         if (held_count > 0) begin
            limit               = held_end[0];
            pick.meeting_number = held_pos[0];
            pick.last_of_run    = 1'b0;
            pick.overflowed     = dropped;
            run = {run, pick};
            for (int i = 1; i < held_count; i++) begin
               // strictly later start than the last chosen end
               if (held_start[i] > limit) begin
                  limit               = held_end[i];
                  pick.meeting_number = held_pos[i];
                  run = {run, pick};
               end
            end
            run[run.size()-1].last_of_run = 1'b1;
            picks_pending = {picks_pending, run};
         end
         held_count = 0;
         arrivals   = 0;
         dropped    = 1'b0;
      endfunction

      function void check_pick(rsp_type got);
         rsp_type want;
         if (picks_pending.size() == 0) begin
            $error("unexpected response beat: meeting_number %0d last_of_run %0b",
                   got.meeting_number, got.last_of_run);
            fails++;
            return;
         end
         want = picks_pending.pop_front();
         picks_checked++;
         if (got.meeting_number !== want.meeting_number) begin
            $error("meeting_number: expected %0d, actual %0d",
                   want.meeting_number, got.meeting_number);
            fails++;
         end
         if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, actual %0b",
                   want.last_of_run, got.last_of_run);
            fails++;
         end
         if (got.overflowed !== want.overflowed) begin
            $error("overflowed: expected %0b, actual %0b",
                   want.overflowed, got.overflowed);
            fails++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req;
   logic    rsp_valid;
   rsp_type rsp;

   schedule_scoreboard sb;
   int                 cycle_count;

   interval_schedule_select_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Hang guard: a stuck busy or a missing pick ends the run here.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Response side cannot stall: every strobed beat is checked at the edge
   // that ends its cycle. Values read here are the pre-edge ones.
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_pick(rsp);
   end

   // Build one meeting. Styles steer the content:
   //   0 - any 16-bit times, reversed intervals included
   //   1 - short meetings over a narrow span, so many picks survive
   //   2 - few distinct end times, lots of ties
   //   3 - back-to-back meetings, start landing on or just past prior ends
   function automatic req_type make_meeting(int style, bit closing);
      req_type item;
      int      base;
      case (style)
         0: begin
            item.start_time = ISS_FIELD_W'($urandom);
            item.end_time   = ISS_FIELD_W'($urandom);
         end
         1: begin
            base            = $urandom_range(0, 2000);
            item.start_time = ISS_FIELD_W'(base);
            item.end_time   = ISS_FIELD_W'(base + $urandom_range(0, 40));
         end
         2: begin
            item.start_time = ISS_FIELD_W'($urandom_range(0, 63));
            item.end_time   = ISS_FIELD_W'($urandom_range(0, 7) * 8);
         end
         default: begin
            base            = $urandom_range(0, 31) * 4;
            item.start_time = ISS_FIELD_W'(base + $urandom_range(0, 1));
            item.end_time   = ISS_FIELD_W'(base + 4);
         end
      endcase
      item.last_meeting = closing;
      return item;
   endfunction

   // Called just after a falling edge. Idles with start low for the gap, then holds the
   // beat until it is taken (start high with busy low at a rising edge).
   task automatic send_meeting(req_type item, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req   <= item;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      sb.note_meeting(item);
      @(negedge clock);
   endtask

   task automatic send_directed(logic [15:0] st, logic [15:0] en, bit closing);
      req_type item;
      item.start_time   = st;
      item.end_time     = en;
      item.last_meeting = closing;
      send_meeting(item, $urandom_range(0, 3));
   endtask

   initial begin
      int set_size;
      int style;
      int gap;
      int sent;
      int set_index;
      bit no_idle;

      sb    = new();
      reset = 1'b1;
      start = 1'b0;
      req   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed sets ----
      // lone meeting at time zero
      send_directed(16'd0, 16'd0, 1'b1);
      // equal ends keep arrival order; a start equal to the chosen end
      // is not picked
      send_directed(16'd100, 16'd200, 1'b0);
      send_directed(16'd150, 16'd200, 1'b0);
      send_directed(16'd200, 16'd300, 1'b0);
      send_directed(16'd201, 16'hFFFF, 1'b0);
      send_directed(16'hFFFF, 16'hFFFF, 1'b1);
      // reversed intervals sort by their end like any other
      send_directed(16'd500, 16'd10, 1'b0);
      send_directed(16'd0, 16'd5, 1'b0);
      send_directed(16'd6, 16'd9, 1'b0);
      send_directed(16'd11, 16'd400, 1'b1);
      // all ends tied: only the first arrival is picked
      send_directed(16'd5, 16'd50, 1'b0);
      send_directed(16'd1, 16'd50, 1'b0);
      send_directed(16'd0, 16'd50, 1'b1);
      // field extremes
      send_directed(16'hFFFF, 16'd0, 1'b0);
      send_directed(16'd0, 16'hFFFF, 1'b0);
      send_directed(16'hFFFF, 16'hFFFF, 1'b0);
      send_directed(16'd0, 16'd0, 1'b1);
      // disjoint chain arriving in reverse order: every one is picked
      send_directed(16'd6, 16'd7, 1'b0);
      send_directed(16'd4, 16'd5, 1'b0);
      send_directed(16'd2, 16'd3, 1'b0);
      send_directed(16'd0, 16'd1, 1'b1);

      // ---- random sets ----
      // First set overruns the store; later ones are mostly short, with an
      // occasional set near or past capacity.
      sent      = 0;
      set_index = 0;
      while (sent < RANDOM_ITEMS) begin
         if (set_index == 0)
            set_size = $urandom_range(MEETING_SLOTS + 1, MEETING_SLOTS + 4);
         else if ($urandom_range(0, 14) == 0)
            set_size = $urandom_range(MEETING_SLOTS - 4, MEETING_SLOTS + 2);
         else
            set_size = $urandom_range(1, 10);
         style   = $urandom_range(0, 3);
         no_idle = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < set_size; i++) begin
            gap = no_idle ? 0 : $urandom_range(0, 11);
            send_meeting(make_meeting(style, i == set_size - 1), gap);
            sent++;
         end
         set_index++;
      end
      start <= 1'b0;

      // drain: wait out every pick, then at least a full scan's worth of quiet cycles
      while (sb.picks_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.picks_pending.size() != 0) begin
         $error("%0d picks never arrived", sb.picks_pending.size());
         sb.fails++;
      end
      $display("Covered %0d meetings in %0d sets (%0d with dropped meetings),",
               sb.meetings_taken, sb.sets_closed, sb.overflow_sets);
      $display("and checked %0d schedule picks.", sb.picks_checked);
      if (sb.fails == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
